// ===== hw/rtl/c2ll_pkg.sv =====
// Shared widths, payload types and the arctangent table function for the lon/lat converter.
package c2ll_pkg;

	// Field widths of the transaction payloads
	localparam int COORD_W = 32;
	localparam int ANGLE_W = 32;

	// Internal angle format: fraction bits of one turn
	localparam int TURN_BITS = 48;
	localparam int QW = TURN_BITS - 1;
	localparam int RND_G = TURN_BITS - ANGLE_W;

	// CORDIC operand and datapath widths
	localparam int OP_W = 32;
	localparam int PRE_SHIFT = 28;
	localparam int XW = 63;
	localparam int ZW = TURN_BITS + 1;
	localparam int CORDIC_STEPS = TURN_BITS + 1;

	// Square root of x^2 + y^2
	localparam int ROOT_W = OP_W;
	localparam int RAD_W = 2 * ROOT_W;

	// Normalizer: magnitude with a word of zeros below it
	localparam int NORM_W = COORD_W + OP_W;
	localparam int NORM_STEPS = $clog2(COORD_W);

	localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
	localparam logic [QW-1:0] QUARTER_TURN = {1'b1, {(TURN_BITS - 2){1'b0}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} point_t;

	typedef struct packed {
		logic [ANGLE_W-1:0]        lon_angle;
		logic signed [ANGLE_W-1:0] lat_angle;
	} angles_t;

	// Coordinate signs, needed after the angle units
	typedef struct packed {
		logic x_neg;
		logic y_neg;
		logic z_neg;
	} sign_t;

	// Side data that rides along the square root pipeline
	typedef struct packed {
		logic [OP_W-1:0] lon_a;
		logic [OP_W-1:0] lon_b;
		logic [OP_W-2:0] lat_z;
		sign_t           sgn;
	} sqrt_tag_t;

	// Unsigned 64-bit quotient by restoring shift and subtract; table build only
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], num[b]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// atan(2^-idx) in turns, TURN_BITS fraction bits, truncated; evaluated at elaboration
	function automatic logic [TURN_BITS-1:0] atan_entry(input int idx);
		logic [63:0]  rad;
		logic [63:0]  term;
		logic [63:0]  den;
		logic [127:0] prod;
		logic         add_term;
		int           e;
		rad = '0;
		term = '0;
		den = 64'd1;
		add_term = 1'b1;
		if (idx == 0) begin
			return TURN_BITS'(64'd1 << (TURN_BITS - 3));
		end
		// arctangent series in radians, 62 fraction bits
		for (e = 62 - idx; e >= 0; e = e - 2 * idx) begin
			term = udiv64(64'd1 << e, den);
			rad = add_term ? rad + term : rad - term;
			add_term = ~add_term;
			den = den + 64'd2;
		end
		prod = {64'd0, rad} * {64'd0, INV_TWO_PI_Q64};
		return TURN_BITS'(prod[127:64] >> (62 - TURN_BITS));
	endfunction

endpackage

// ===== hw/rtl/c2ll_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module c2ll_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [c2ll_pkg::RAD_W-1:0]  in_rad,
	input  c2ll_pkg::sqrt_tag_t         in_tag,
	output logic                        out_valid,
	output logic [c2ll_pkg::ROOT_W-1:0] out_root,
	output c2ll_pkg::sqrt_tag_t         out_tag
);
	import c2ll_pkg::*;

	localparam int RW = ROOT_W + 2;

	logic              vld_s  [0:ROOT_W-1];
	logic [RW-1:0]     rem_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [0:ROOT_W-1];
	logic [RAD_W-1:0]  rad_s  [0:ROOT_W-2];
	sqrt_tag_t         tag_s  [0:ROOT_W-1];

	// One restoring step per stage: bring down two radicand bits, try 4*root+1
	for (genvar j = 0; j < ROOT_W; j++) begin : g_step
		logic              vld_p;
		logic [RW-1:0]     rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [RAD_W-1:0]  rad_p;
		sqrt_tag_t         tag_p;
		logic [RW+1:0]     cur;
		logic [RW+1:0]     trial;
		logic              ge;

		if (j == 0) begin : g_first
			assign vld_p  = in_valid;
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = in_rad;
			assign tag_p  = in_tag;
		end else begin : g_next
			assign vld_p  = vld_s[j-1];
			assign rem_p  = rem_s[j-1];
			assign root_p = root_s[j-1];
			assign rad_p  = rad_s[j-1];
			assign tag_p  = tag_s[j-1];
		end

		assign cur   = {rem_p, rad_p[RAD_W-1 -: 2]};
		assign trial = (RW + 2)'({root_p, 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j]  <= ge ? RW'(cur - trial) : RW'(cur);
			root_s[j] <= {root_p[ROOT_W-2:0], ge};
			tag_s[j]  <= tag_p;
		end

		if (j < ROOT_W - 1) begin : g_rad
			always_ff @(posedge clk) begin
				rad_s[j] <= rad_p << 2;
			end
		end
	end

	// Round up when the remainder exceeds the floor root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[ROOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		out_root <= ROOT_W'(root_s[ROOT_W-1] +
			ROOT_W'(rem_s[ROOT_W-1] > RW'(root_s[ROOT_W-1])));
		out_tag  <= tag_s[ROOT_W-1];
	end

	// remainder of a floor root never exceeds twice the root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ROOT_W-1] |-> rem_s[ROOT_W-1] <= RW'({root_s[ROOT_W-1], 1'b0}))
		else $error("isqrt remainder out of range");

endmodule

// ===== hw/rtl/c2ll_cordic.sv =====
// Unrolled vectoring CORDIC: atan2(b, a) for a, b >= 0, result in [0, quarter turn].
module c2ll_cordic (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [c2ll_pkg::OP_W-1:0] in_a,
	input  logic [c2ll_pkg::OP_W-1:0] in_b,
	input  c2ll_pkg::sign_t           in_tag,
	output logic                      out_valid,
	output logic [c2ll_pkg::QW-1:0]   out_angle,
	output c2ll_pkg::sign_t           out_tag
);
	import c2ll_pkg::*;

	localparam int NS = CORDIC_STEPS;
	localparam int LAT = NS + 2;

	logic                 vld_s [0:NS];
	logic signed [XW-1:0] x_s   [0:NS];
	logic signed [XW-1:0] y_s   [0:NS];
	logic signed [ZW-1:0] z_s   [0:NS];
	logic                 za_s  [0:NS];
	logic                 zb_s  [0:NS];
	sign_t                tag_s [0:NS];

	// Entry stage: scale operands, note the axis cases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]   <= $signed(XW'({in_a, {PRE_SHIFT{1'b0}}}));
		y_s[0]   <= $signed(XW'({in_b, {PRE_SHIFT{1'b0}}}));
		z_s[0]   <= '0;
		za_s[0]  <= (in_a == '0);
		zb_s[0]  <= (in_b == '0);
		tag_s[0] <= in_tag;
	end

	// One micro-rotation per stage, driving y toward zero
	for (genvar i = 0; i < NS; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ATAN_T = ZW'(atan_entry(i));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (!y_s[i][XW-1]) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + ATAN_T;
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - ATAN_T;
			end
			za_s[i+1]  <= za_s[i];
			zb_s[i+1]  <= zb_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	// Output: axis cases exact, otherwise clamp to [0, quarter]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		priority if (zb_s[NS]) begin
			out_angle <= '0;
		end else if (za_s[NS]) begin
			out_angle <= QUARTER_TURN;
		end else if (z_s[NS][ZW-1]) begin
			out_angle <= '0;
		end else if (z_s[NS] > $signed(ZW'(QUARTER_TURN))) begin
			out_angle <= QUARTER_TURN;
		end else begin
			out_angle <= QW'(z_s[NS]);
		end
		out_tag <= tag_s[NS];
	end

	a_zero_b: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(in_valid && (in_b == '0), LAT) |-> out_angle == '0)
		else $error("cordic: zero ordinate must give zero angle");

	a_zero_a: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(in_valid && (in_b != '0) && (in_a == '0), LAT)
		|-> out_angle == QUARTER_TURN)
		else $error("cordic: zero abscissa must give a quarter turn");

endmodule

// ===== hw/rtl/cartesian_to_lon_lat.sv =====
// Cartesian point to longitude and latitude as binary angles, fully pipelined.
// Path: the normalizer (5 stages), squares and sum, a 33-stage square root and a
//   51-stage CORDIC.
// Throughput: one transaction per clock; busy is never asserted.
// Each result is held on result for the single cycle that done marks; no stall.
// Reset clears every valid bit; transactions in flight are dropped.
module cartesian_to_lon_lat (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  c2ll_pkg::point_t  point,
	output logic              busy,
	output logic              done,
	output c2ll_pkg::angles_t result
);
	import c2ll_pkg::*;

	localparam int LON_W = TURN_BITS + 1;
	localparam int LAT_W = TURN_BITS;
	localparam int SQ_W  = 2 * (OP_W - 1);
	localparam logic [LON_W-1:0] HALF_TURN = {2'b01, {(TURN_BITS - 1){1'b0}}};
	localparam logic [LON_W-1:0] FULL_TURN = {1'b1, {TURN_BITS{1'b0}}};
	localparam logic [LON_W-1:0] RND_LON   = LON_W'(1) << (RND_G - 1);
	localparam logic signed [LAT_W-1:0] RND_LAT = LAT_W'(1) << (RND_G - 1);
	localparam logic signed [ANGLE_W-1:0] LAT_LIM = {2'b01, {(ANGLE_W - 2){1'b0}}};

	function automatic logic [COORD_W-1:0] magn(input logic [COORD_W-1:0] v);
		return v[COORD_W-1] ? COORD_W'(~v + COORD_W'(1)) : v;
	endfunction

	logic accept;

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// Stage 1: magnitudes and signs
	logic               vld_s1;
	logic [COORD_W-1:0] ax_s1, ay_s1, az_s1;
	sign_t              sgn_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1        <= magn(point.coord_x);
		ay_s1        <= magn(point.coord_y);
		az_s1        <= magn(point.coord_z);
		sgn_s1.x_neg <= point.coord_x[COORD_W-1];
		sgn_s1.y_neg <= point.coord_y[COORD_W-1];
		sgn_s1.z_neg <= point.coord_z[COORD_W-1];
	end

	// Stage 2: max of |x|,|y| and max of all three, compares in parallel
	logic               vld_s2;
	logic [COORD_W-1:0] ax_s2, ay_s2, az_s2, mxy_s2, mall_s2;
	sign_t              sgn_s2;
	logic               gt_xy, gt_xz, gt_yz;

	assign gt_xy = ax_s1 > ay_s1;
	assign gt_xz = ax_s1 > az_s1;
	assign gt_yz = ay_s1 > az_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s2   <= ax_s1;
		ay_s2   <= ay_s1;
		az_s2   <= az_s1;
		sgn_s2  <= sgn_s1;
		mxy_s2  <= gt_xy ? ax_s1 : ay_s1;
		mall_s2 <= gt_xy ? (gt_xz ? ax_s1 : az_s1) : (gt_yz ? ay_s1 : az_s1);
	end

	// Normalizer: shift each group left until its max has its top bit at the MSB
	logic              vld_sn [0:NORM_STEPS-1];
	logic [NORM_W-1:0] lx_sn  [0:NORM_STEPS-1];
	logic [NORM_W-1:0] ly_sn  [0:NORM_STEPS-1];
	logic [NORM_W-1:0] lm_sn  [0:NORM_STEPS-1];
	logic [NORM_W-1:0] tx_sn  [0:NORM_STEPS-1];
	logic [NORM_W-1:0] ty_sn  [0:NORM_STEPS-1];
	logic [NORM_W-1:0] tz_sn  [0:NORM_STEPS-1];
	logic [NORM_W-1:0] tm_sn  [0:NORM_STEPS-1];
	sign_t             sgn_sn [0:NORM_STEPS-1];

	for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
		localparam int SH = 1 << (NORM_STEPS - 1 - k);
		logic              vld_p;
		logic [NORM_W-1:0] lx_p, ly_p, lm_p, tx_p, ty_p, tz_p, tm_p;
		sign_t             sgn_p;
		logic              lsh, tsh;

		if (k == 0) begin : g_first
			assign vld_p = vld_s2;
			assign lx_p  = {ax_s2, {OP_W{1'b0}}};
			assign ly_p  = {ay_s2, {OP_W{1'b0}}};
			assign lm_p  = {mxy_s2, {OP_W{1'b0}}};
			assign tx_p  = {ax_s2, {OP_W{1'b0}}};
			assign ty_p  = {ay_s2, {OP_W{1'b0}}};
			assign tz_p  = {az_s2, {OP_W{1'b0}}};
			assign tm_p  = {mall_s2, {OP_W{1'b0}}};
			assign sgn_p = sgn_s2;
		end else begin : g_next
			assign vld_p = vld_sn[k-1];
			assign lx_p  = lx_sn[k-1];
			assign ly_p  = ly_sn[k-1];
			assign lm_p  = lm_sn[k-1];
			assign tx_p  = tx_sn[k-1];
			assign ty_p  = ty_sn[k-1];
			assign tz_p  = tz_sn[k-1];
			assign tm_p  = tm_sn[k-1];
			assign sgn_p = sgn_sn[k-1];
		end

		assign lsh = ~|lm_p[NORM_W-1 -: SH];
		assign tsh = ~|tm_p[NORM_W-1 -: SH];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else begin
				vld_sn[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			lx_sn[k]  <= lsh ? (lx_p << SH) : lx_p;
			ly_sn[k]  <= lsh ? (ly_p << SH) : ly_p;
			lm_sn[k]  <= lsh ? (lm_p << SH) : lm_p;
			tx_sn[k]  <= tsh ? (tx_p << SH) : tx_p;
			ty_sn[k]  <= tsh ? (ty_p << SH) : ty_p;
			tz_sn[k]  <= tsh ? (tz_p << SH) : tz_p;
			tm_sn[k]  <= tsh ? (tm_p << SH) : tm_p;
			sgn_sn[k] <= sgn_p;
		end
	end

	// Longitude operands keep top bit at 31, latitude operands at 30
	localparam int NL = NORM_STEPS - 1;
	logic [OP_W-2:0] nx, ny;

	assign nx = tx_sn[NL][NORM_W-1 -: OP_W-1];
	assign ny = ty_sn[NL][NORM_W-1 -: OP_W-1];

	// Stage 3: squares
	logic            vld_s3;
	logic [SQ_W-1:0] sqx_s3, sqy_s3;
	sqrt_tag_t       tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_sn[NL];
		end
	end

	always_ff @(posedge clk) begin
		sqx_s3       <= SQ_W'(nx) * SQ_W'(nx);
		sqy_s3       <= SQ_W'(ny) * SQ_W'(ny);
		tag_s3.lon_a <= lx_sn[NL][NORM_W-1 -: OP_W];
		tag_s3.lon_b <= ly_sn[NL][NORM_W-1 -: OP_W];
		tag_s3.lat_z <= tz_sn[NL][NORM_W-1 -: OP_W-1];
		tag_s3.sgn   <= sgn_sn[NL];
	end

	// Stage 4: x^2 + y^2
	logic             vld_s4;
	logic [RAD_W-1:0] rad_s4;
	sqrt_tag_t        tag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		rad_s4 <= RAD_W'(sqx_s3) + RAD_W'(sqy_s3);
		tag_s4 <= tag_s3;
	end

	// Radius in the xy plane
	logic              root_vld;
	logic [ROOT_W-1:0] root;
	sqrt_tag_t         root_tag;

	c2ll_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_rad    (rad_s4),
		.in_tag    (tag_s4),
		.out_valid (root_vld),
		.out_root  (root),
		.out_tag   (root_tag)
	);

	// Both arctangents run in lockstep
	logic          lon_vld, lat_vld;
	logic [QW-1:0] lon_th, lat_th;
	sign_t         lon_sgn, lat_sgn;

	c2ll_cordic u_lon_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_vld),
		.in_a      (root_tag.lon_a),
		.in_b      (root_tag.lon_b),
		.in_tag    (root_tag.sgn),
		.out_valid (lon_vld),
		.out_angle (lon_th),
		.out_tag   (lon_sgn)
	);

	c2ll_cordic u_lat_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (root_vld),
		.in_a      (root),
		.in_b      ({1'b0, root_tag.lat_z}),
		.in_tag    (root_tag.sgn),
		.out_valid (lat_vld),
		.out_angle (lat_th),
		.out_tag   (lat_sgn)
	);

	// Stage 5: place the angles by quadrant and sign
	logic                    vld_s5;
	logic [LON_W-1:0]        lon_s5;
	logic signed [LAT_W-1:0] lat_s5;
	logic [LON_W-1:0]        lon_th_w;
	logic signed [LAT_W-1:0] lat_th_w;

	assign lon_th_w = LON_W'(lon_th);
	assign lat_th_w = $signed({1'b0, lat_th});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= lat_vld;
		end
	end

	always_ff @(posedge clk) begin
		unique case ({lat_sgn.x_neg, lat_sgn.y_neg})
			2'b11: lon_s5 <= HALF_TURN + lon_th_w;
			2'b10: lon_s5 <= HALF_TURN - lon_th_w;
			2'b01: lon_s5 <= FULL_TURN - lon_th_w;
			default: lon_s5 <= lon_th_w;
		endcase
		lat_s5 <= lat_sgn.z_neg ? -lat_th_w : lat_th_w;
	end

	// Output stage: round to the result step; a full turn wraps to zero
	logic [LON_W-1:0]        lon_rnd;
	logic signed [LAT_W-1:0] lat_rnd;

	assign lon_rnd = lon_s5 + RND_LON;
	assign lat_rnd = lat_s5 + RND_LAT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		result.lon_angle <= lon_rnd[RND_G +: ANGLE_W];
		result.lat_angle <= lat_rnd[RND_G +: ANGLE_W];
	end

	// the two angle pipelines must stay in step on the same transaction
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(lon_vld == lat_vld) && (!lat_vld || lon_sgn == lat_sgn))
		else $error("longitude and latitude pipelines out of step");

	a_lat_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(result.lat_angle) <= LAT_LIM) &&
			($signed(result.lat_angle) >= -LAT_LIM))
		else $error("latitude beyond a quarter turn");

endmodule

// ===== sim/cartesian_to_lon_lat_tb.sv =====
// Self-checking testbench for the Cartesian point to longitude/latitude converter.
module cartesian_to_lon_lat_tb;
	import c2ll_pkg::*;

	// Internal angle format of the predictor: fraction bits of a turn, then rounding guard
	localparam int FRAC = 48;
	localparam int GUARD = FRAC - ANGLE_W;
	localparam int STEPS = FRAC + 1;
	localparam longint QUARTER_T = longint'(1) <<< (FRAC - 2);
	localparam bit [63:0] HALF_T = 64'd1 << (FRAC - 1);
	localparam bit [63:0] FULL_T = 64'd1 << FRAC;
	localparam bit [63:0] SERIES_INV_2PI = 64'h28BE60DB9391054A;

	// Coordinate extremes and exact output angles
	localparam int CMAX = 32'h7FFF_FFFF;
	localparam int CMIN = 32'h8000_0000;
	localparam bit [31:0] ANG_ZERO = 32'h0000_0000;
	localparam bit [31:0] ANG_QUARTER = 32'h4000_0000;
	localparam bit [31:0] ANG_HALF = 32'h8000_0000;
	localparam bit [31:0] ANG_3QUARTER = 32'hC000_0000;
	localparam bit [31:0] ANG_NEG_QUARTER = 32'hC000_0000;

	localparam int PIPE_LATENCY = 94;
	localparam int DRAIN_CYCLES = PIPE_LATENCY + 60;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_POINTS = 1100;

	typedef struct {
		point_t  pt;
		bit      known;
		angles_t want;
	} point_row_t;

	logic    clk;
	logic    arst_n;
	logic    start;
	point_t  point;
	logic    busy;
	logic    done;
	angles_t result;

	longint     atan_step [0:STEPS-1];
	angles_t    pending_angles[$];
	point_row_t directed_rows[$];
	int         points_sent;
	int         results_checked;
	int         errors;

	cartesian_to_lon_lat DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.point  (point),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// atan(2^-i) in turns, truncated, from the radian series scaled by 1/(2*pi)
	initial begin : build_atan_table
		bit [63:0]  rad;
		bit [63:0]  term;
		bit [63:0]  den;
		bit [127:0] prod;
		bit         add_term;
		int         e;
		atan_step[0] = longint'(1) <<< (FRAC - 3);
		for (int i = 1; i < STEPS; i++) begin
			rad = '0;
			den = 64'd1;
			add_term = 1'b1;
			for (e = 62 - i; e >= 0; e = e - 2 * i) begin
				term = (64'd1 << e) / den;
				rad = add_term ? rad + term : rad - term;
				add_term = ~add_term;
				den = den + 64'd2;
			end
			prod = {64'd0, rad} * {64'd0, SERIES_INV_2PI};
			atan_step[i] = longint'(prod[127:64] >> (62 - FRAC));
		end
	end

	function automatic bit [31:0] abs_coord(bit [31:0] v);
		return v[31] ? ~v + 32'd1 : v;
	endfunction

	function automatic int msb_index(bit [63:0] m);
		int p;
		p = 0;
		while (p < 63 && (m >> (p + 1)) != 0)
			p++;
		return p;
	endfunction

	function automatic bit [63:0] scale(bit [63:0] v, int s);
		return s >= 0 ? v << s : v >> (-s);
	endfunction

	// Integer square root, rounded to nearest
	function automatic bit [63:0] root_nearest(bit [63:0] s);
		bit [63:0] res;
		bit [63:0] b;
		res = '0;
		b = 64'd1 << 62;
		while (b > s)
			b = b >> 2;
		while (b != 0) begin
			if (s >= res + b) begin
				s = s - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		if (s > res)
			res = res + 64'd1;
		return res;
	endfunction

	// Vectoring CORDIC: atan2(b, a) in turns for a, b >= 0, clamped to a quarter turn
	function automatic longint vector_angle(bit [63:0] a, bit [63:0] b);
		longint xa;
		longint yb;
		longint acc;
		longint dx;
		longint dy;
		if (b == 0)
			return 0;
		if (a == 0)
			return QUARTER_T;
		xa = a << 28;
		yb = b << 28;
		acc = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = yb >>> i;
			dy = xa >>> i;
			if (yb >= 0) begin
				xa = xa + dx;
				yb = yb - dy;
				acc = acc + atan_step[i];
			end else begin
				xa = xa - dx;
				yb = yb + dy;
				acc = acc - atan_step[i];
			end
		end
		if (acc < 0)
			acc = 0;
		if (acc > QUARTER_T)
			acc = QUARTER_T;
		return acc;
	endfunction

	// Expected longitude and latitude of one point
	function automatic angles_t lon_lat_of(point_t p);
		bit [63:0] ax;
		bit [63:0] ay;
		bit [63:0] az;
		bit [63:0] mxy;
		bit [63:0] mall;
		bit [63:0] nx;
		bit [63:0] ny;
		bit [63:0] nz;
		bit [63:0] lon;
		bit [63:0] lon_r;
		longint    th;
		longint    lat;
		longint    lat_r;
		int        s;
		angles_t   r;
		ax = abs_coord(p.coord_x);
		ay = abs_coord(p.coord_y);
		az = abs_coord(p.coord_z);
		mxy = ax > ay ? ax : ay;
		mall = mxy > az ? mxy : az;
		lon = '0;
		lat = 0;
		// longitude: quadrant from the signs, angle from the magnitudes
		if (mxy != 0) begin
			s = 31 - msb_index(mxy);
			th = vector_angle(scale(ax, s), scale(ay, s));
			if (p.coord_x[31])
				lon = p.coord_y[31] ? HALF_T + th : HALF_T - th;
			else
				lon = p.coord_y[31] ? FULL_T - th : th;
		end
		// latitude: z against the rounded horizontal radius
		if (mall != 0) begin
			s = 30 - msb_index(mall);
			nx = scale(ax, s);
			ny = scale(ay, s);
			nz = scale(az, s);
			th = vector_angle(root_nearest(nx * nx + ny * ny), nz);
			lat = p.coord_z[31] ? -th : th;
		end
		lon_r = (lon + (64'd1 << (GUARD - 1))) >> GUARD;
		lat_r = (lat + (longint'(1) <<< (GUARD - 1))) >>> GUARD;
		r.lon_angle = lon_r[ANGLE_W-1:0];
		r.lat_angle = lat_r[ANGLE_W-1:0];
		return r;
	endfunction

	function automatic void add_row(int x, int y, int z, bit known,
			bit [31:0] lon, bit [31:0] lat);
		point_row_t row;
		row.pt = '{coord_x: x, coord_y: y, coord_z: z};
		row.known = known;
		row.want = '{lon_angle: lon, lat_angle: lat};
		directed_rows.push_back(row);
	endfunction

	// Coordinate of random magnitude: zeros, extremes, full words and every bit width
	function automatic int rand_coord();
		bit [31:0] v;
		int w;
		case ($urandom_range(0, 9))
			0: v = '0;
			1: begin
				case ($urandom_range(0, 3))
					0: v = CMAX;
					1: v = CMIN;
					2: v = 32'd1;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			2, 3: v = $urandom;
			default: begin
				w = $urandom_range(1, 31);
				v = $urandom & ((32'h1 << w) - 32'd1);
				if ($urandom_range(0, 1))
					v = ~v + 32'd1;
			end
		endcase
		return v;
	endfunction

	function automatic point_t rand_point();
		point_t p;
		p.coord_x = rand_coord();
		p.coord_y = rand_coord();
		p.coord_z = rand_coord();
		case ($urandom_range(0, 9))
			0: begin
				p.coord_x = '0;
				p.coord_y = '0;
			end
			1: p.coord_z = '0;
			2: begin
				if ($urandom_range(0, 1))
					p.coord_x = '0;
				else
					p.coord_y = '0;
			end
			3: begin
				// close to an axis: one tiny component, longitude near a quadrant edge
				p.coord_y = $urandom_range(0, 3);
				if ($urandom_range(0, 1))
					p.coord_y = -p.coord_y;
			end
			default: ;
		endcase
		return p;
	endfunction

	// Idle cycles before the next transaction; runs of back-to-back transactions
	function automatic int pick_gap(int idx);
		int r;
		if ((idx / 64) % 4 == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 60);
	endfunction

	task automatic send_point(input point_t p, input angles_t want);
		@(negedge clk);
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy);
		pending_angles.push_back(want);
		points_sent++;
	endtask

	task automatic idle_gap(input int n);
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			point <= {$urandom, $urandom, $urandom};
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Result checker: each strobe is matched with the oldest expectation
	always @(posedge clk) begin : check_results
		angles_t want;
		if (arst_n && done) begin
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected result lon=%h lat=%h", $time,
					result.lon_angle, result.lat_angle);
				errors++;
			end else begin
				want = pending_angles.pop_front();
				results_checked++;
				if (result.lon_angle !== want.lon_angle) begin
					$display("%0t: lon_angle expected %h actual %h", $time,
						want.lon_angle, result.lon_angle);
					errors++;
				end
				if (result.lat_angle !== want.lat_angle) begin
					$display("%0t: lat_angle expected %h actual %h", $time,
						want.lat_angle, result.lat_angle);
					errors++;
				end
			end
		end
	end

	// Watchdog: too many cycles with no transaction in either direction
	initial begin : watchdog
		int stalled;
		stalled = 0;
		do begin
			@(posedge clk);
			if ((start && !busy) || done)
				stalled = 0;
			else
				stalled++;
		end while (stalled < STALL_LIMIT);
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("cartesian_to_lon_lat regression: fail");
		$finish;
	end

	initial begin : stimulus
		point_t  p;
		angles_t want;
		arst_n = 1'b0;
		start = 1'b0;
		point = '0;
		points_sent = 0;
		results_checked = 0;
		errors = 0;

		// origin, each half axis, extremes of every field
		add_row(0, 0, 0, 1, ANG_ZERO, ANG_ZERO);
		add_row(1, 0, 0, 1, ANG_ZERO, ANG_ZERO);
		add_row(CMAX, 0, 0, 1, ANG_ZERO, ANG_ZERO);
		add_row(-1, 0, 0, 1, ANG_HALF, ANG_ZERO);
		add_row(CMIN, 0, 0, 1, ANG_HALF, ANG_ZERO);
		add_row(0, 1, 0, 1, ANG_QUARTER, ANG_ZERO);
		add_row(0, CMAX, 0, 1, ANG_QUARTER, ANG_ZERO);
		add_row(0, CMIN, 0, 1, ANG_3QUARTER, ANG_ZERO);
		add_row(0, -5, 0, 1, ANG_3QUARTER, ANG_ZERO);
		add_row(0, 0, 1, 1, ANG_ZERO, ANG_QUARTER);
		add_row(0, 0, CMAX, 1, ANG_ZERO, ANG_QUARTER);
		add_row(0, 0, CMIN, 1, ANG_ZERO, ANG_NEG_QUARTER);
		add_row(0, 0, -7, 1, ANG_ZERO, ANG_NEG_QUARTER);
		// just below a full turn; the first rounds and wraps to zero
		add_row(CMAX, -1, 0, 0, '0, '0);
		add_row(1000000, -1, 3, 0, '0, '0);
		// diagonals and mixed extremes
		add_row(CMAX, CMAX, CMAX, 0, '0, '0);
		add_row(CMIN, CMIN, CMIN, 0, '0, '0);
		add_row(CMIN, CMAX, 0, 0, '0, '0);
		add_row(CMAX, CMIN, CMIN, 0, '0, '0);
		add_row(-1, -1, 1, 0, '0, '0);
		add_row(3, -4, 12, 0, '0, '0);
		add_row(1, 1, CMIN, 0, '0, '0);
		add_row(CMIN, 1, CMAX, 0, '0, '0);
		add_row(-12345, 67890, -1, 0, '0, '0);
		add_row(1, -1, 0, 0, '0, '0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			want = directed_rows[i].known ? directed_rows[i].want
				: lon_lat_of(directed_rows[i].pt);
			send_point(directed_rows[i].pt, want);
			idle_gap(pick_gap(i));
		end

		for (int n = 0; n < RANDOM_POINTS; n++) begin
			p = rand_point();
			send_point(p, lon_lat_of(p));
			idle_gap(pick_gap(n));
		end
		@(negedge clk);
		start <= 1'b0;

		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d points sent (%0d directed: axes, extremes, wrap at a full turn), %0d results checked",
			points_sent, directed_rows.size(), results_checked);
		$display("%0d field mismatches", errors);
		if (errors == 0)
			$display("cartesian_to_lon_lat regression: pass");
		else
			$display("cartesian_to_lon_lat regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/c2ll_pkg.sv
hw/rtl/c2ll_isqrt.sv
hw/rtl/c2ll_cordic.sv
hw/rtl/cartesian_to_lon_lat.sv
sim/cartesian_to_lon_lat_tb.sv
